@@ design/llst_pkg.sv @@
// ----------------------------------------------------------------------------
// llst_pkg
// Shared types and codes for the linked list store: transfer payloads,
// operation codes and result status codes.
// ----------------------------------------------------------------------------
package llst_pkg;

    typedef struct packed {
        logic [2:0]         func;
        logic [5:0]         index;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic [1:0]         status;
        logic               last;
    } t_out_item;

    localparam logic [2:0] FUNC_READ     = 3'd0;
    localparam logic [2:0] FUNC_INS_HEAD = 3'd1;
    localparam logic [2:0] FUNC_INS_TAIL = 3'd2;
    localparam logic [2:0] FUNC_REMOVE   = 3'd3;
    localparam logic [2:0] FUNC_DUMP     = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic signed [31:0] VALUE_NOT_FOUND = -32'sd1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

endpackage

@@ design/llst_fifo.sv @@
// ----------------------------------------------------------------------------
// llst_fifo
// Short command queue between the front and the back of the list store.
// ----------------------------------------------------------------------------
module llst_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  llst_pkg::t_in_item i_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_pop,
    output llst_pkg::t_in_item o_data
);
    import llst_pkg::*;

    t_in_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] n_count;
    logic                   push_ok;
    logic                   pop_ok;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + QUEUE_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop_ok ? r_rd_ptr + QUEUE_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + QUEUE_CNT_W'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ design/llst_front.sv @@
// ----------------------------------------------------------------------------
// llst_front
// Input stage: takes each transfer, drops unused operation codes and hands
// the rest to the command queue.
// ----------------------------------------------------------------------------
module llst_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  llst_pkg::t_in_item i_item,
    output logic               o_push,
    output llst_pkg::t_in_item o_cmd,
    input  logic               i_q_full
);
    import llst_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;
    logic     accept;
    logic     legal;
    logic     load;

    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_q_full;
    assign o_cmd   = r_item;
    assign load    = o_push || !r_valid;

    always_comb begin
        unique case (i_item.func) inside
            FUNC_READ, FUNC_INS_HEAD, FUNC_INS_TAIL, FUNC_REMOVE, FUNC_DUMP: legal = 1'b1;
            default: legal = 1'b0;
        endcase
        n_valid = load ? (accept && legal) : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

endmodule

@@ design/llst_back.sv @@
// ----------------------------------------------------------------------------
// llst_back
// Executes queued commands against the slot pool: walks links one slot per
// cycle, keeps head, tail and free list, and drives the result register.
// ----------------------------------------------------------------------------
module llst_back #(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  llst_pkg::t_in_item  i_cmd,
    output logic                o_cmd_pop,
    output logic                o_res_valid,
    output llst_pkg::t_out_item o_res,
    input  logic                i_res_stall
);
    import llst_pkg::*;

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_WALK     = 4'd2;
    localparam logic [3:0] S_RMNEXT   = 4'd3;
    localparam logic [3:0] S_RMHEAD   = 4'd4;
    localparam logic [3:0] S_RELEASE  = 4'd5;
    localparam logic [3:0] S_ALLOC    = 4'd6;
    localparam logic [3:0] S_INSERT   = 4'd7;
    localparam logic [3:0] S_LINKTAIL = 4'd8;
    localparam logic [3:0] S_DUMP     = 4'd9;
    localparam logic [3:0] S_RESP     = 4'd10;

    logic signed [31:0] r_val_mem  [CAPACITY];
    logic [SLOT_W-1:0]  r_link_mem [CAPACITY];
    logic signed [31:0] r_val_q;
    logic [SLOT_W-1:0]  r_link_q;

    logic [3:0]         r_state,      n_state;
    t_in_item           r_cmd,        n_cmd;
    logic [SLOT_W-1:0]  r_head,       n_head;
    logic [SLOT_W-1:0]  r_tail,       n_tail;
    logic [SLOT_W-1:0]  r_free_head,  n_free_head;
    logic [CNT_W-1:0]   r_free_cnt,   n_free_cnt;
    logic [CNT_W-1:0]   r_fresh_cnt,  n_fresh_cnt;
    logic [CNT_W-1:0]   r_elem_cnt,   n_elem_cnt;
    logic [SLOT_W-1:0]  r_cur,        n_cur;
    logic [SLOT_W-1:0]  r_prev,       n_prev;
    logic [SLOT_W-1:0]  r_steps,      n_steps;
    logic signed [31:0] r_res_value,  n_res_value;
    logic [1:0]         r_res_status, n_res_status;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic               lk_we;
    logic [SLOT_W-1:0]  lk_waddr;
    logic [SLOT_W-1:0]  lk_wdata;
    logic               vl_we;
    logic               out_free;
    logic               out_load;
    t_out_item          out_data;
    logic [6:0]         idx_ext;
    logic [6:0]         elem_ext;

    assign out_free    = !r_out_valid || !i_res_stall;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign idx_ext     = 7'(r_cmd.index);
    assign elem_ext    = 7'(r_elem_cnt);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_head       = r_head;
        n_tail       = r_tail;
        n_free_head  = r_free_head;
        n_free_cnt   = r_free_cnt;
        n_fresh_cnt  = r_fresh_cnt;
        n_elem_cnt   = r_elem_cnt;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_steps      = r_steps;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        o_cmd_pop    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_cur;
        lk_we        = 1'b0;
        lk_waddr     = r_cur;
        lk_wdata     = '0;
        vl_we        = 1'b0;
        out_load     = 1'b0;
        out_data     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_cmd.func) inside
                    FUNC_READ: begin
                        if (idx_ext >= elem_ext) begin
                            n_res_value  = VALUE_NOT_FOUND;
                            n_res_status = ST_NOTFOUND;
                            n_state      = S_RESP;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_cur   = r_head;
                            n_steps = SLOT_W'(r_cmd.index);
                            n_state = S_WALK;
                        end
                    end
                    FUNC_INS_HEAD, FUNC_INS_TAIL: begin
                        if (r_free_cnt != '0) begin
                            rd_en   = 1'b1;
                            rd_addr = r_free_head;
                            n_cur   = r_free_head;
                            n_state = S_ALLOC;
                        end else if (r_fresh_cnt < CNT_W'(CAPACITY)) begin
                            n_cur       = SLOT_W'(r_fresh_cnt);
                            n_fresh_cnt = r_fresh_cnt + CNT_W'(1);
                            n_state     = S_INSERT;
                        end else begin
                            n_res_value  = '0;
                            n_res_status = ST_FULL;
                            n_state      = S_RESP;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (idx_ext >= elem_ext) begin
                            n_res_value  = '0;
                            n_res_status = ST_NOTFOUND;
                            n_state      = S_RESP;
                        end else if (r_cmd.index == '0) begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_cur   = r_head;
                            n_state = S_RMHEAD;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_cur   = r_head;
                            n_steps = SLOT_W'(r_cmd.index - 6'd1);
                            n_state = S_WALK;
                        end
                    end
                    FUNC_DUMP: begin
                        if (r_elem_cnt == '0) begin
                            n_res_value  = '0;
                            n_res_status = ST_EMPTY;
                            n_state      = S_RESP;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_cur   = r_head;
                            n_steps = SLOT_W'(r_elem_cnt - CNT_W'(1));
                            n_state = S_DUMP;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_WALK: begin
                if (r_steps == '0) begin
                    if (r_cmd.func == FUNC_READ) begin
                        n_res_value  = r_val_q;
                        n_res_status = ST_OK;
                        n_state      = S_RESP;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_link_q;
                        n_prev  = r_cur;
                        n_cur   = r_link_q;
                        n_state = S_RMNEXT;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_link_q;
                    n_cur   = r_link_q;
                    n_steps = r_steps - SLOT_W'(1);
                end
            end
            S_RMNEXT: begin
                lk_we    = 1'b1;
                lk_waddr = r_prev;
                lk_wdata = r_link_q;
                if (r_cur == r_tail) begin
                    n_tail = r_prev;
                end
                n_state = S_RELEASE;
            end
            S_RMHEAD: begin
                n_head  = r_link_q;
                n_state = S_RELEASE;
            end
            S_RELEASE: begin
                lk_we       = 1'b1;
                lk_waddr    = r_cur;
                lk_wdata    = r_free_head;
                n_free_head = r_cur;
                n_free_cnt  = r_free_cnt + CNT_W'(1);
                n_elem_cnt  = r_elem_cnt - CNT_W'(1);
                if (r_elem_cnt == CNT_W'(1)) begin
                    n_head = '0;
                    n_tail = '0;
                end
                n_res_value  = '0;
                n_res_status = ST_OK;
                n_state      = S_RESP;
            end
            S_ALLOC: begin
                n_free_head = r_link_q;
                n_free_cnt  = r_free_cnt - CNT_W'(1);
                n_state     = S_INSERT;
            end
            S_INSERT: begin
                vl_we    = 1'b1;
                lk_we    = 1'b1;
                lk_waddr = r_cur;
                n_res_value  = '0;
                n_res_status = ST_OK;
                if (r_cmd.func == FUNC_INS_HEAD) begin
                    lk_wdata = r_head;
                    n_head   = r_cur;
                    if (r_elem_cnt == '0) begin
                        n_tail = r_cur;
                    end
                    n_elem_cnt = r_elem_cnt + CNT_W'(1);
                    n_state    = S_RESP;
                end else if (r_elem_cnt == '0) begin
                    lk_wdata   = '0;
                    n_head     = r_cur;
                    n_tail     = r_cur;
                    n_elem_cnt = r_elem_cnt + CNT_W'(1);
                    n_state    = S_RESP;
                end else begin
                    lk_wdata = '0;
                    n_state  = S_LINKTAIL;
                end
            end
            S_LINKTAIL: begin
                lk_we      = 1'b1;
                lk_waddr   = r_tail;
                lk_wdata   = r_cur;
                n_tail     = r_cur;
                n_elem_cnt = r_elem_cnt + CNT_W'(1);
                n_state    = S_RESP;
            end
            S_DUMP: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_data.value_res = r_val_q;
                    out_data.status    = ST_OK;
                    out_data.last      = (r_steps == '0);
                    if (r_steps == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_link_q;
                        n_cur   = r_link_q;
                        n_steps = r_steps - SLOT_W'(1);
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_data.value_res = r_res_value;
                    out_data.status    = r_res_status;
                    out_data.last      = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_free_head <= '0;
            r_free_cnt  <= '0;
            r_fresh_cnt <= '0;
            r_elem_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_free_head <= n_free_head;
            r_free_cnt  <= n_free_cnt;
            r_fresh_cnt <= n_fresh_cnt;
            r_elem_cnt  <= n_elem_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_steps      <= n_steps;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vl_we) begin
            r_val_mem[r_cur] <= r_cmd.value;
        end
        if (lk_we) begin
            r_link_mem[lk_waddr] <= lk_wdata;
        end
        if (rd_en) begin
            r_val_q  <= r_val_mem[rd_addr];
            r_link_q <= r_link_mem[rd_addr];
        end
    end

endmodule

@@ design/linked_list_store.sv @@
// ----------------------------------------------------------------------------
// linked_list_store
// Bounded singly linked list over a pool of CAPACITY slots with read,
// head and tail insert, remove at position and in-order dump.
// ----------------------------------------------------------------------------
// Items pass one at a time through the list engine. A front register and a
// four-entry queue let the input side keep taking transfers while an item is
// being worked on, and an item passes through both before the engine takes
// it. An insert takes an extra step to pop a reused slot off the free list
// and another to link a new tail to a non-empty list; a read or remove follows
// the links from the head up to the index, and a dump walks every element in
// order. Out-of-range, pool full and empty cases are answered without a walk.
// The link memory is read one slot per cycle while following the list, but a
// dump waits while its result is stalled. Results sit in an output register;
// a stalled result holds the engine, and the input side stalls once the queue
// fills. Inserts into a full pool are dropped and answered with the pool full
// status; freed slots are reused before never-used ones.
// ----------------------------------------------------------------------------
module linked_list_store #(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  llst_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output llst_pkg::t_out_item o_item
);
    import llst_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    t_in_item front_cmd;
    t_in_item q_cmd;

    llst_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_push   (q_push),
        .o_cmd    (front_cmd),
        .i_q_full (q_full)
    );

    llst_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_cmd)
    );

    llst_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_res_valid (o_valid),
        .o_res       (o_item),
        .i_res_stall (i_stall)
    );

endmodule
